// File: sv/ckc_pkg.sv
// Shared constants, types and the base decoder for the canonical k-mer counter.
// No dependencies; imported by ckc_count_table, canonical_kmer_counter_core and the testbench.
package ckc_pkg;

  localparam int MAX_K_DEF      = 8;
  localparam int COUNT_BITS_DEF = 32;

  // fixed field widths
  localparam int KLEN_W    = 4;
  localparam int CHAR_W    = 8;
  localparam int QIDX_W    = 16;
  localparam int CODE_W    = 16;
  localparam int COUNT_W   = 32;
  localparam int S_TDATA_W = 32;  // 25 bits of fields, padded to bytes
  localparam int M_TDATA_W = 48;

  // request kinds (s_axis_tuser)
  localparam logic REQ_SEQ   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result kinds (m_axis_tuser)
  localparam logic RES_COUNTED = 1'b0;
  localparam logic RES_READ    = 1'b1;

  // characters
  localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_UG = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_UT = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_LG = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_LT = 8'h74;

  // 2-bit base codes
  localparam logic [1:0] BASE_A = 2'b00;
  localparam logic [1:0] BASE_C = 2'b01;
  localparam logic [1:0] BASE_G = 2'b10;
  localparam logic [1:0] BASE_T = 2'b11;

  typedef struct packed {
    logic is_base;
    logic [1:0] code;
  } base_t;

  // control of a table access issued by the front end
  typedef struct packed {
    logic valid;
    logic is_query;
  } tbl_req_t;

  function automatic base_t decode_base(input logic [CHAR_W-1:0] ch);
    base_t r;
    r.is_base = 1'b1;
    r.code    = BASE_A;
    case (ch)
      CHAR_UA, CHAR_LA: r.code = BASE_A;
      CHAR_UC, CHAR_LC: r.code = BASE_C;
      CHAR_UG, CHAR_LG: r.code = BASE_G;
      CHAR_UT, CHAR_LT: r.code = BASE_T;
      default:          r.is_base = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/canonical_kmer_counter_core.sv
// Canonical k-mer counter top level: window tracking, config register, output
// register. Uses ckc_pkg and ckc_count_table.
//
// Usage:
//   s_axis_*: requests. tuser selects a sequence character or a count query.
//     A character updates the forward and reverse-complement window; once k
//     bases are held, each base counts its canonical k-mer and yields one
//     result. Newlines are skipped, other non-bases clear the window and
//     yield nothing. A query yields the stored count of one code.
//   m_axis_*: results, code and count (counts saturate).
//   cfg_*: writes kmer_length; always ready, clears the window, keeps counts.
//     Write only while the block is idle.
// Latency: table read register, then output register. Throughput: one request per
//   cycle while s_axis_tready is high, set by the single read-modify-write of the
//   count table; a count to the same code in the next cycle is forwarded from the last write.
// Reset: kmer_length = MAX_K, window cleared, then the count table is swept to
//   zero, one entry a cycle, all 4**MAX_K entries (65536 by default); s_axis_tready
//   stays low during the sweep.
// Stall: a result waits in the output register; while it is held, one more
//   request may enter and then s_axis_tready drops until m_axis_tready rises.
module canonical_kmer_counter_core #(
  parameter int MAX_K      = ckc_pkg::MAX_K_DEF,
  parameter int COUNT_BITS = ckc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // char_code[7:0], first_of_region[8], query_index[24:9], zero pad
  input  logic [ckc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // kmer_code[15:0], kmer_count[47:16]
  output logic [ckc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // result_kind[0]
  output logic                          m_axis_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckc_pkg::KLEN_W-1:0]    cfg_data
);
  import ckc_pkg::*;

  localparam int TB = 2 * MAX_K;

  // input fields
  logic [CHAR_W-1:0] in_char;
  logic              in_first;
  logic [QIDX_W-1:0] in_qidx;
  logic              accept;

  logic [KLEN_W-1:0] kmer_length;
  logic [TB-1:0]     fwd, fwd_next;
  logic [TB-1:0]     rev, rev_next;
  logic [KLEN_W-1:0] valid_run, valid_run_next;

  logic [KLEN_W-1:0] k_eff;
  logic [4:0]        kx2;
  logic [4:0]        rc_shamt;
  logic [TB-1:0]     kmask;
  base_t             base;
  logic [TB-1:0]     f0, r0;
  logic [KLEN_W-1:0] v0;
  logic              emit;
  logic [TB-1:0]     canon;
  logic [31:0]       qidx_ext;

  tbl_req_t              req;
  logic [TB-1:0]         req_addr;
  logic                  advance;
  logic                  busy;
  logic                  res_valid;
  logic                  res_query;
  logic [TB-1:0]         res_addr;
  logic [COUNT_BITS-1:0] res_count;
  logic [31:0]           addr_ext;
  logic [63:0]           count_ext;

  logic              out_kind;
  logic [CODE_W-1:0] out_code;
  logic [COUNT_W-1:0] out_count;

  assign in_char  = s_axis_tdata[CHAR_W-1:0];
  assign in_first = s_axis_tdata[CHAR_W];
  assign in_qidx  = s_axis_tdata[CHAR_W+QIDX_W:CHAR_W+1];

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !busy && (!res_valid || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kmer_length > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end else begin
      k_eff = kmer_length;
    end
    kx2      = {k_eff, 1'b0};
    rc_shamt = {k_eff - 1'b1, 1'b0};
    for (int i = 0; i < TB; i++) begin
      kmask[i] = 5'(i) < kx2;
    end
  end

  // window update for a sequence character
  always_comb begin
    base = decode_base(in_char);
    f0   = in_first ? '0 : fwd;
    r0   = in_first ? '0 : rev;
    v0   = in_first ? '0 : valid_run;
    emit = 1'b0;
    fwd_next       = f0;
    rev_next       = r0;
    valid_run_next = v0;
    if (in_char == CHAR_NL) begin
      // skipped, window kept
    end else if (!base.is_base) begin
      fwd_next       = '0;
      rev_next       = '0;
      valid_run_next = '0;
    end else begin
      fwd_next = ((f0 << 2) | TB'(base.code)) & kmask;
      rev_next = ((r0 >> 2) | (TB'(~base.code) << rc_shamt)) & kmask;
      valid_run_next = (v0 < k_eff) ? v0 + 1'b1 : v0;
      emit = valid_run_next >= k_eff;
    end
    canon = (fwd_next < rev_next) ? fwd_next : rev_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KLEN_W'(MAX_K);
      fwd         <= '0;
      rev         <= '0;
      valid_run   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      kmer_length <= cfg_data;
      fwd         <= '0;
      rev         <= '0;
      valid_run   <= '0;
    end else if (accept && s_axis_tuser == REQ_SEQ) begin
      fwd       <= fwd_next;
      rev       <= rev_next;
      valid_run <= valid_run_next;
    end
  end

  always_comb begin
    qidx_ext     = 32'(in_qidx);
    req.is_query = s_axis_tuser == REQ_QUERY;
    req.valid    = accept && (req.is_query || emit);
    req_addr     = req.is_query ? qidx_ext[TB-1:0] : canon;
  end

  ckc_count_table #(
    .MAX_K      (MAX_K),
    .COUNT_BITS (COUNT_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_addr  (req_addr),
    .advance   (advance),
    .busy      (busy),
    .res_valid (res_valid),
    .res_query (res_query),
    .res_addr  (res_addr),
    .res_count (res_count)
  );

  assign addr_ext  = 32'(res_addr);
  assign count_ext = 64'(res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind  <= res_query ? RES_READ : RES_COUNTED;
      out_code  <= addr_ext[CODE_W-1:0];
      out_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign m_axis_tdata = {out_count, out_code};
  assign m_axis_tuser = out_kind;

endmodule

// File: sv/ckc_count_table.sv
// Count table: one synchronous memory with clearing sweep after reset,
// saturating read-modify-write and write-to-read forwarding. Uses ckc_pkg.
module ckc_count_table #(
  parameter int MAX_K      = ckc_pkg::MAX_K_DEF,
  parameter int COUNT_BITS = ckc_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ckc_pkg::tbl_req_t      req,
  input  logic [2*MAX_K-1:0]     req_addr,
  input  logic                   advance,
  output logic                   busy,
  output logic                   res_valid,
  output logic                   res_query,
  output logic [2*MAX_K-1:0]     res_addr,
  output logic [COUNT_BITS-1:0]  res_count
);
  import ckc_pkg::*;

  localparam int TB    = 2 * MAX_K;
  localparam int DEPTH = 1 << TB;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] mem [0:DEPTH-1];
  logic [COUNT_BITS-1:0] rd_data;

  logic          clearing;
  logic [TB-1:0] clr_addr;

  logic          s1_v;
  logic          s1_query;
  logic [TB-1:0] s1_addr;

  logic                  lw_v;
  logic [TB-1:0]         lw_addr;
  logic [COUNT_BITS-1:0] lw_data;

  logic                  we;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cnt_next;

  assign busy = clearing;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) rd_data <= mem[req_addr];
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[s1_addr] <= cnt_next;
    end
  end

  // entry in flight between read and write
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (req.valid) begin
      s1_v <= 1'b1;
    end else if (advance) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_query <= req.is_query;
      s1_addr  <= req_addr;
    end
  end

  // latest write; its data matches memory until the next write
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_v <= 1'b0;
    end else if (we) begin
      lw_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lw_addr <= s1_addr;
      lw_data <= cnt_next;
    end
  end

  always_comb begin
    cur      = (lw_v && lw_addr == s1_addr) ? lw_data : rd_data;
    cnt_next = (cur == CNT_MAX) ? cur : cur + 1'b1;
    we       = s1_v && advance && !s1_query;
  end

  assign res_valid = s1_v;
  assign res_query = s1_query;
  assign res_addr  = s1_addr;
  assign res_count = s1_query ? cur : cnt_next;

endmodule

// File: tb/sv/kmer_count_checker.sv
`timescale 1ns / 1ps
// Checker for canonical_kmer_counter_core: watches the request, result and config channels,
// keeps its own window and count table, and compares every result with the oldest awaited one.
// Depends on ckc_pkg for widths and codes.
module kmer_count_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [ckc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [ckc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          m_axis_tuser,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ckc_pkg::KLEN_W-1:0]    cfg_data,
  output int unsigned                   outstanding,
  output int unsigned                   errors
);
  import ckc_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
  } count_result_t;

  count_result_t      awaited_counts[$];
  logic [COUNT_W-1:0] tallies [0:65535];
  logic [KLEN_W-1:0]  klen;
  logic [CODE_W-1:0]  fwd_code;
  logic [CODE_W-1:0]  rc_code;
  int unsigned        bases_held;

  // 0..3 for a base, 4 for anything else
  function automatic int unsigned base_value(input logic [CHAR_W-1:0] ch);
    case (ch)
      CHAR_UA, CHAR_LA: return 32'(BASE_A);
      CHAR_UC, CHAR_LC: return 32'(BASE_C);
      CHAR_UG, CHAR_LG: return 32'(BASE_G);
      CHAR_UT, CHAR_LT: return 32'(BASE_T);
      default:          return 4;
    endcase
  endfunction

  task automatic clear_window();
    fwd_code   = '0;
    rc_code    = '0;
    bases_held = 0;
  endtask

  task automatic count_request(input logic req, input logic [CHAR_W-1:0] ch,
                               input logic first, input logic [QIDX_W-1:0] qidx);
    int unsigned        k;
    int unsigned        b;
    logic [31:0]        span;
    logic [CODE_W-1:0]  kmask;
    logic [CODE_W-1:0]  comp;
    logic [CODE_W-1:0]  canon;
    count_result_t      r;
    if (req == REQ_QUERY) begin
      r.kind  = RES_READ;
      r.code  = qidx;
      r.count = tallies[qidx];
      awaited_counts = {awaited_counts, r};
    end else begin
      if (first) clear_window();
      if (ch != CHAR_NL) begin
        b = base_value(ch);
        if (b > 3) begin
          clear_window();
        end else begin
          // out-of-range lengths clamp to 1..MAX_K
          k = (klen == 0) ? 1 : ((klen > MAX_K_DEF) ? MAX_K_DEF : 32'(klen));
          span  = (32'd1 << (2 * k)) - 32'd1;
          kmask = span[CODE_W-1:0];
          comp  = CODE_W'(3 - b);
          fwd_code = ((fwd_code << 2) | CODE_W'(b)) & kmask;
          rc_code  = ((rc_code >> 2) | (comp << (2 * (k - 1)))) & kmask;
          if (bases_held < k) bases_held++;
          if (bases_held >= k) begin
            canon = (fwd_code < rc_code) ? fwd_code : rc_code;
            if (tallies[canon] != '1) tallies[canon] = tallies[canon] + 1'b1;
            r.kind  = RES_COUNTED;
            r.code  = canon;
            r.count = tallies[canon];
            awaited_counts = {awaited_counts, r};
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    count_result_t want;
    logic [CODE_W-1:0]  got_code;
    logic [COUNT_W-1:0] got_count;
    if (rst) begin
      klen = KLEN_W'(MAX_K_DEF);
      clear_window();
      for (int i = 0; i < 65536; i++) tallies[i] = '0;
      awaited_counts.delete();
      errors = 0;
    end else begin
      // results first: a request taken in this cycle cannot have answered yet
      if (m_axis_tvalid && m_axis_tready) begin
        got_code  = m_axis_tdata[CODE_W-1:0];
        got_count = m_axis_tdata[CODE_W+COUNT_W-1:CODE_W];
        if (awaited_counts.size() == 0) begin
          $error("result with nothing awaited: kind %0d code %0h count %0d",
                 m_axis_tuser, got_code, got_count);
          errors++;
        end else begin
          want = awaited_counts.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            errors++;
          end
          if (got_code !== want.code) begin
            $error("kmer_code: expected %0h, got %0h", want.code, got_code);
            errors++;
          end
          if (got_count !== want.count) begin
            $error("kmer_count: expected %0d, got %0d", want.count, got_count);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        klen = cfg_data;
        clear_window();
      end
      if (s_axis_tvalid && s_axis_tready)
        count_request(s_axis_tuser, s_axis_tdata[CHAR_W-1:0], s_axis_tdata[CHAR_W],
                      s_axis_tdata[CHAR_W+QIDX_W:CHAR_W+1]);
    end
    outstanding <= awaited_counts.size();
  end

endmodule

// File: tb/sv/canonical_kmer_counter_core_tb.sv
`timescale 1ns / 1ps
// Top of the k-mer counter testbench: clock, reset, request and config stimulus, verdict.
// Depends on ckc_pkg, canonical_kmer_counter_core and kmer_count_checker.
module canonical_kmer_counter_core_tb;
  import ckc_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 300000;  // covers the table sweep after reset
  localparam int SEGMENT_ITEMS  = 320;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [KLEN_W-1:0]    cfg_data;

  int unsigned outstanding;
  int unsigned check_errors;
  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 50;
  int unsigned quiet_cycles;

  always #2 clk = ~clk;

  canonical_kmer_counter_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  kmer_count_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .errors       (check_errors)
  );

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // leaves tvalid high after the handshake; the caller lowers it
  task automatic push_request(input logic req, input logic [CHAR_W-1:0] ch,
                              input logic first, input logic [QIDX_W-1:0] qidx);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'b0, qidx, first, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic first);
    push_request(REQ_SEQ, ch, first, 16'($urandom));
  endtask

  task automatic send_query(input logic [QIDX_W-1:0] qidx);
    push_request(REQ_QUERY, 8'($urandom), 1'($urandom_range(0, 1)), qidx);
  endtask

  // stop sending, let every awaited result out, then allow for requests with no result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_klen(input logic [KLEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] base_char(input int unsigned sel);
    case (sel)
      0:       return CHAR_UA;
      1:       return CHAR_UC;
      2:       return CHAR_UG;
      3:       return CHAR_UT;
      4:       return CHAR_LA;
      5:       return CHAR_LC;
      6:       return CHAR_LG;
      default: return CHAR_LT;
    endcase
  endfunction

  initial begin
    logic [KLEN_W-1:0] seg_klen [6];
    int unsigned       keff;
    int unsigned       roll;
    logic [QIDX_W-1:0] span_mask;
    logic              first;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_SEQ;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset length 8: a newline inside the window must not break it
    send_char(CHAR_UA, 1'b0);
    send_char(CHAR_UC, 1'b0);
    send_char(CHAR_UG, 1'b0);
    send_char(CHAR_UT, 1'b0);
    send_char(CHAR_NL, 1'b0);
    send_char(CHAR_LA, 1'b0);
    send_char(CHAR_LC, 1'b0);
    send_char(CHAR_LG, 1'b0);
    send_char(CHAR_LT, 1'b0);
    send_char(CHAR_UT, 1'b0);
    // non-bases clear the window
    send_char(8'h4E, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    push_request(REQ_QUERY, 8'hFF, 1'b1, 16'hFFFF);
    push_request(REQ_QUERY, CHAR_UA, 1'b0, 16'h0000);
    send_char(CHAR_UG, 1'b1);
    wait_idle();

    // length 1: every base counts, A/T and C/G share a canonical code
    write_klen(4'd1);
    send_char(CHAR_UA, 1'b0);
    send_char(CHAR_UC, 1'b0);
    send_char(CHAR_UG, 1'b0);
    send_char(CHAR_UT, 1'b0);
    send_char(CHAR_LA, 1'b1);
    send_query(16'h0000);
    send_query(16'h0001);
    send_char(CHAR_NL, 1'b1);
    wait_idle();

    seg_klen[0] = 4'd0;
    seg_klen[1] = 4'd15;
    seg_klen[2] = 4'd8;
    seg_klen[3] = 4'd1;
    seg_klen[4] = 4'($urandom_range(2, 7));
    seg_klen[5] = 4'($urandom_range(2, 7));

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_klen(seg_klen[seg]);
      keff = (seg_klen[seg] == 0) ? 1 :
             ((seg_klen[seg] > MAX_K_DEF) ? MAX_K_DEF : 32'(seg_klen[seg]));
      span_mask = 16'((32'd1 << (2 * keff)) - 32'd1);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        roll  = $urandom_range(0, 99);
        first = ($urandom_range(0, 99) < 3);
        if (roll < 8)       send_query(16'($urandom));
        else if (roll < 15) send_query(16'($urandom) & span_mask);
        else if (roll < 19) send_char(8'($urandom), first);
        else if (roll < 23) send_char(CHAR_NL, first);
        else                send_char(base_char($urandom_range(0, 7)), first);
      end
      wait_idle();
    end

    if (check_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
